/* rtl/assert_macros.svh */
// Assertion macros shared by the execute unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SRE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SRE_ASSERT(lbl, clk, rstn, prop, msg)
`define SRE_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/sre_pkg.sv */
// Types, codes and defaults shared by the execute unit modules.
package sre_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned PC_INDEX_DEF  = 15;
  localparam int unsigned SP_INDEX_DEF  = 14;
  localparam int unsigned NUM_REGS      = 16;

  // host operation codes
  localparam logic [2:0] OPN_EXEC   = 3'd0;
  localparam logic [2:0] OPN_MEM_WR = 3'd1;
  localparam logic [2:0] OPN_MEM_RD = 3'd2;
  localparam logic [2:0] OPN_REG_WR = 3'd3;
  localparam logic [2:0] OPN_REG_RD = 3'd4;
  localparam logic [2:0] OPN_CR_RD  = 3'd5;

  localparam logic [3:0] OPC_LAST = 4'd9;

  // fault codes
  localparam logic [1:0] FLT_NONE   = 2'd0;
  localparam logic [1:0] FLT_BAD    = 2'd1;
  localparam logic [1:0] FLT_DIV0   = 2'd2;
  localparam logic [1:0] FLT_HALTED = 2'd3;

  // control register indexes
  localparam logic [3:0] CR_STATUS  = 4'd0;
  localparam logic [3:0] CR_HANDLER = 4'd1;
  localparam logic [3:0] CR_CAUSE   = 4'd2;

  localparam logic [31:0] SWI_CAUSE   = 32'd4;
  localparam logic [31:0] STATUS_MASK = ~32'h1;
  localparam logic [11:0] DISP_SIGN   = 12'h800;

  // modifiers
  localparam logic [3:0] MD_CALL_DIR = 4'd0;
  localparam logic [3:0] MD_CALL_IND = 4'd1;
  localparam logic [3:0] MD_JMP_ALW  = 4'd0;
  localparam logic [3:0] MD_JMP_AIND = 4'd8;
  localparam logic [2:0] JC_ALWAYS   = 3'd0;
  localparam logic [2:0] JC_EQ       = 3'd1;
  localparam logic [2:0] JC_NE       = 3'd2;
  localparam logic [2:0] JC_GT       = 3'd3;
  localparam int unsigned JMP_IND_BIT = 3;
  localparam logic [3:0] MD_ADD = 4'd0;
  localparam logic [3:0] MD_SUB = 4'd1;
  localparam logic [3:0] MD_MUL = 4'd2;
  localparam logic [3:0] MD_DIV = 4'd3;
  localparam logic [3:0] MD_NOT = 4'd0;
  localparam logic [3:0] MD_AND = 4'd1;
  localparam logic [3:0] MD_OR  = 4'd2;
  localparam logic [3:0] MD_XOR = 4'd3;
  localparam logic [3:0] MD_SHL = 4'd0;
  localparam logic [3:0] MD_SAR = 4'd1;
  localparam logic [3:0] MD_ST_IDX = 4'd0;
  localparam logic [3:0] MD_ST_PRE = 4'd1;
  localparam logic [3:0] MD_ST_IND = 4'd2;
  localparam logic [3:0] MD_LD_CR   = 4'd0;
  localparam logic [3:0] MD_LD_ADDI = 4'd1;
  localparam logic [3:0] MD_LD_IDX  = 4'd2;
  localparam logic [3:0] MD_LD_POST = 4'd3;
  localparam logic [3:0] MD_CR_MOV  = 4'd4;
  localparam logic [3:0] MD_CR_OR   = 4'd5;
  localparam logic [3:0] MD_CR_IDX  = 4'd6;
  localparam logic [3:0] MD_CR_POST = 4'd7;

  typedef enum logic [2:0] {
    K_EXEC, K_MEM_WR, K_MEM_RD, K_REG_WR, K_REG_RD, K_CR_RD, K_BAD
  } kind_e;

  typedef enum logic [3:0] {
    OPC_HALT, OPC_SWI, OPC_CALL, OPC_JUMP, OPC_SWAP,
    OPC_ARITH, OPC_LOGIC, OPC_SHIFT, OPC_STORE, OPC_LOAD
  } opc_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_DEC, ST_HRD, ST_HREG, ST_RDC, ST_EXEC,
    ST_STEP2, ST_STEP3, ST_MRD, ST_DIV, ST_FIN
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic        bad_opc;
    opc_e        opc;
    logic [3:0]  md;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [3:0]  rc;
    logic [31:0] disp;
    logic [15:0] haddr;
    logic [31:0] hdata;
    logic [3:0]  rsel;
  } item_t;

  typedef struct packed {
    logic        clearing;
    logic        done;
    logic [31:0] pc;
    logic        running;
    logic [31:0] rd;
    logic [1:0]  fault;
  } stat_t;

endpackage

/* rtl/sre_front.sv */
// Front end: classifies incoming words and queues them for the back end.
module sre_front import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        hold_i,
  input  logic [2:0]  operation_i,
  input  logic [31:0] instr_word_i,
  input  logic [15:0] host_address_i,
  input  logic [31:0] host_data_i,
  input  logic [3:0]  reg_select_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output item_t       item_o
);

  item_t      slot_q [2];
  item_t      dec;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push_ok;
  logic [11:0] d12;

  always_comb begin
    d12         = {instr_word_i[7:0], instr_word_i[11:8]};
    dec.hdata   = host_data_i;
    dec.haddr   = host_address_i;
    dec.rsel    = reg_select_i;
    dec.md      = instr_word_i[27:24];
    dec.ra      = instr_word_i[23:20];
    dec.rb      = instr_word_i[19:16];
    dec.rc      = instr_word_i[15:12];
    dec.disp    = {{20{(d12 & DISP_SIGN) != 12'h0}}, d12};
    dec.bad_opc = instr_word_i[31:28] > OPC_LAST;
    dec.opc     = dec.bad_opc ? OPC_HALT : opc_e'(instr_word_i[31:28]);
    unique case (operation_i)
      OPN_EXEC:   dec.kind = K_EXEC;
      OPN_MEM_WR: dec.kind = K_MEM_WR;
      OPN_MEM_RD: dec.kind = K_MEM_RD;
      OPN_REG_WR: dec.kind = K_REG_WR;
      OPN_REG_RD: dec.kind = K_REG_RD;
      OPN_CR_RD:  dec.kind = K_CR_RD;
      default:    dec.kind = K_BAD;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2) || hold_i;
  assign push_ok = push_i && !full_o;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)   rd_ptr_q <= ~rd_ptr_q;
      if (push_ok && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_ok) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/sre_div.sv */
// Iterative signed divider, one quotient bit per cycle.
module sre_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] rem_sh, diff;

  assign rem_sh     = {rem_q, quo_q[31]};
  assign diff       = rem_sh - {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_q <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_q <= dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/sre_back.sv */
// Back end: sequencer, register file, control registers and data memory.
module sre_back import sre_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
  parameter int unsigned PC_INDEX  = PC_INDEX_DEF,
  parameter int unsigned SP_INDEX  = SP_INDEX_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  input  logic  out_ready_i,
  output stat_t stat_o
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RAW  = AW - 2;
  localparam int unsigned ROWS = MEM_BYTES / 4;
  localparam logic [3:0]  PC_IDX = 4'(PC_INDEX);
  localparam logic [3:0]  SP_IDX = 4'(SP_INDEX);

  state_e state_q, state_d;
  item_t  cur_q, cur_d, it;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, loc_q, loc_d, rd_q, rd_d;
  logic [1:0]  fault_q, fault_d;
  logic [31:0] pc_q, sp_q;
  logic        running_q, running_clr;
  logic [31:0] cr_status_q, cr_handler_q, cr_cause_q;
  logic        cr_we, swi_upd;
  logic [3:0]  cr_widx;
  logic [31:0] cr_wdata;
  logic [RAW-1:0] clr_row_q;

  // register file
  logic [31:0]         rf_q [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid_q;
  logic        rf_we;
  logic [3:0]  rf_waddr, rd0_idx, rd1_idx;
  logic [31:0] rf_wdata, rd0_q, rd1_q;

  // data memory
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata, bank_wdata, bank_rdata_q;
  logic [RAW-1:0] bank_row [4];
  logic          bank_we;
  logic [1:0]    rd_lo_q;
  logic [63:0]   w64, r64;

  logic        div_start, div_done;
  logic [31:0] div_quo;
  logic [31:0] pc4, c_now, a_call, b_call, shl_res, sar_res;
  logic        jmp_take, jmp_ind;

  function automatic logic [AW-1:0] maddr(input logic [31:0] x);
    return x[AW-1:0];
  endfunction

  function automatic logic [31:0] cr_pick(input logic [3:0] idx, input logic [31:0] st,
                                          input logic [31:0] hd, input logic [31:0] ca);
    logic [31:0] v;
    unique case (idx)
      CR_STATUS:  v = st;
      CR_HANDLER: v = hd;
      CR_CAUSE:   v = ca;
      default:    v = '0;
    endcase
    return v;
  endfunction

  sre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (b_q),
    .divisor_i  (c_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign it     = cur_q;
  assign pc4    = pc_q + 32'd4;
  assign c_now  = rd0_q;
  assign a_call = (it.ra == SP_IDX) ? (sp_q - 32'd4) : a_q;
  assign b_call = (it.rb == SP_IDX) ? (sp_q - 32'd4) : b_q;
  assign shl_res = (c_q > 32'd31) ? 32'd0 : (b_q << c_q[4:0]);
  assign sar_res = (c_q > 32'd31) ? {32{b_q[31]}} : 32'($signed(b_q) >>> c_q[4:0]);
  assign jmp_ind = it.md[JMP_IND_BIT];

  always_comb begin
    unique case (it.md[2:0])
      JC_ALWAYS: jmp_take = (it.md == MD_JMP_ALW) || (it.md == MD_JMP_AIND);
      JC_EQ:     jmp_take = b_q == c_now;
      JC_NE:     jmp_take = b_q != c_now;
      JC_GT:     jmp_take = $signed(b_q) > $signed(c_now);
      default:   jmp_take = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_row_q == {RAW{1'b1}}) state_d = ST_DEC;
      ST_DEC: begin
        if (q_valid_i) begin
          unique case (q_item_i.kind)
            K_MEM_RD: state_d = ST_HRD;
            K_REG_RD: state_d = ST_HREG;
            K_EXEC:   state_d = (running_q && !q_item_i.bad_opc) ? ST_RDC : ST_FIN;
            default:  state_d = ST_FIN;
          endcase
        end
      end
      ST_HRD, ST_HREG: state_d = ST_FIN;
      ST_RDC:  state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (it.opc)
          OPC_HALT: state_d = ST_FIN;
          OPC_JUMP: state_d = (jmp_take && jmp_ind) ? ST_MRD : ST_FIN;
          default:  state_d = ST_STEP2;
        endcase
      end
      ST_STEP2: begin
        state_d = ST_FIN;
        unique case (it.opc)
          OPC_SWI, OPC_SWAP: state_d = ST_STEP3;
          OPC_CALL:  if (it.md == MD_CALL_IND) state_d = ST_MRD;
          OPC_ARITH: if (it.md == MD_DIV && c_q != 32'd0) state_d = ST_DIV;
          OPC_STORE: begin
            if (it.md == MD_ST_IND) state_d = ST_MRD;
            if (it.md == MD_ST_PRE) state_d = ST_STEP3;
          end
          OPC_LOAD: begin
            if (it.md == MD_LD_IDX || it.md == MD_LD_POST ||
                it.md == MD_CR_IDX || it.md == MD_CR_POST) state_d = ST_MRD;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_MRD: state_d = (it.opc == OPC_LOAD && it.md == MD_LD_POST) ? ST_STEP3 : ST_FIN;
      ST_STEP3: state_d = ST_FIN;
      ST_DIV:   if (div_done) state_d = ST_FIN;
      ST_FIN:   if (out_ready_i) state_d = ST_DEC;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // datapath controls
  always_comb begin
    cur_d = cur_q; a_d = a_q; b_d = b_q; c_d = c_q; loc_d = loc_q;
    rd_d = rd_q; fault_d = fault_q;
    q_pop_o = 1'b0; running_clr = 1'b0; div_start = 1'b0;
    cr_we = 1'b0; cr_widx = it.ra; cr_wdata = '0; swi_upd = 1'b0;
    rf_we = 1'b0; rf_waddr = it.ra; rf_wdata = '0;
    rd0_idx = it.rc; rd1_idx = it.rb;
    mem_we = 1'b0; mem_addr = '0; mem_wdata = '0;
    unique case (state_q)
      ST_DEC: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          rd_d    = '0;
          fault_d = FLT_NONE;
          unique case (q_item_i.kind)
            K_MEM_WR: begin
              mem_we    = 1'b1;
              mem_addr  = maddr(32'(q_item_i.haddr));
              mem_wdata = q_item_i.hdata;
            end
            K_MEM_RD: mem_addr = maddr(32'(q_item_i.haddr));
            K_REG_WR: begin
              rf_we    = 1'b1;
              rf_waddr = q_item_i.rsel;
              rf_wdata = q_item_i.hdata;
            end
            K_REG_RD: rd0_idx = q_item_i.rsel;
            K_CR_RD:  rd_d = cr_pick(q_item_i.rsel, cr_status_q, cr_handler_q, cr_cause_q);
            K_EXEC: begin
              priority if (!running_q) begin
                fault_d = FLT_HALTED;
              end else if (q_item_i.bad_opc) begin
                fault_d = FLT_BAD;
              end else begin
                rd0_idx = q_item_i.ra;
                rd1_idx = q_item_i.rb;
              end
            end
            default: fault_d = FLT_BAD;
          endcase
        end
      end
      ST_HRD:  rd_d = mem_rdata;
      ST_HREG: rd_d = rd0_q;
      ST_RDC: begin
        a_d = rd0_q;
        b_d = rd1_q;
      end
      ST_EXEC: begin
        c_d = c_now;
        unique case (it.opc)
          OPC_HALT: begin
            rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = pc4;
            running_clr = 1'b1;
          end
          OPC_SWI: begin
            mem_we = 1'b1; mem_addr = maddr(sp_q - 32'd4); mem_wdata = pc4;
          end
          OPC_CALL: begin
            mem_we = 1'b1; mem_addr = maddr(sp_q - 32'd4); mem_wdata = pc4;
            rf_we = 1'b1; rf_waddr = SP_IDX; rf_wdata = sp_q - 32'd4;
            loc_d = a_call + b_call + it.disp;
          end
          OPC_JUMP: begin
            if (jmp_take && jmp_ind) begin
              mem_addr = maddr(a_q + it.disp);
            end else begin
              rf_we = 1'b1; rf_waddr = PC_IDX;
              rf_wdata = jmp_take ? (a_q + it.disp) : pc4;
            end
          end
          OPC_SWAP: begin
            rf_we = 1'b1; rf_waddr = it.rb; rf_wdata = c_now;
          end
          default: begin
            rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = pc4;
          end
        endcase
      end
      ST_STEP2: begin
        unique case (it.opc)
          OPC_SWI: begin
            mem_we = 1'b1; mem_addr = maddr(sp_q - 32'd8); mem_wdata = cr_status_q;
            rf_we = 1'b1; rf_waddr = SP_IDX; rf_wdata = sp_q - 32'd8;
          end
          OPC_CALL: begin
            if (it.md == MD_CALL_DIR) begin
              rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = loc_q;
            end
            mem_addr = maddr(loc_q);
          end
          OPC_SWAP: begin
            rf_we = 1'b1; rf_waddr = it.rc; rf_wdata = b_q;
          end
          OPC_ARITH: begin
            unique case (it.md)
              MD_ADD: begin rf_we = 1'b1; rf_wdata = b_q + c_q; end
              MD_SUB: begin rf_we = 1'b1; rf_wdata = b_q - c_q; end
              MD_MUL: begin rf_we = 1'b1; rf_wdata = 32'(b_q * c_q); end
              MD_DIV: begin
                if (c_q == 32'd0) begin
                  rf_we = 1'b1; rf_wdata = '1; fault_d = FLT_DIV0;
                end else begin
                  div_start = 1'b1;
                end
              end
              default: ;
            endcase
          end
          OPC_LOGIC: begin
            unique case (it.md)
              MD_NOT: begin rf_we = 1'b1; rf_wdata = ~b_q; end
              MD_AND: begin rf_we = 1'b1; rf_wdata = b_q & c_q; end
              MD_OR:  begin rf_we = 1'b1; rf_wdata = b_q | c_q; end
              MD_XOR: begin rf_we = 1'b1; rf_wdata = b_q ^ c_q; end
              default: ;
            endcase
          end
          OPC_SHIFT: begin
            unique case (it.md)
              MD_SHL: begin rf_we = 1'b1; rf_wdata = shl_res; end
              MD_SAR: begin rf_we = 1'b1; rf_wdata = sar_res; end
              default: ;
            endcase
          end
          OPC_STORE: begin
            unique case (it.md)
              MD_ST_IDX: begin
                mem_we = 1'b1; mem_addr = maddr(a_q + b_q + it.disp); mem_wdata = c_q;
              end
              MD_ST_IND: mem_addr = maddr(a_q + b_q + it.disp);
              MD_ST_PRE: begin rf_we = 1'b1; rf_wdata = a_q + it.disp; end
              default: ;
            endcase
          end
          OPC_LOAD: begin
            unique case (it.md)
              MD_LD_CR: begin
                rf_we = 1'b1;
                rf_wdata = cr_pick(it.rb, cr_status_q, cr_handler_q, cr_cause_q);
              end
              MD_LD_ADDI: begin rf_we = 1'b1; rf_wdata = b_q + it.disp; end
              MD_LD_IDX, MD_CR_IDX: mem_addr = maddr(b_q + c_q + it.disp);
              MD_LD_POST, MD_CR_POST: mem_addr = maddr(b_q);
              MD_CR_MOV: begin cr_we = 1'b1; cr_wdata = b_q; end
              MD_CR_OR: begin
                cr_we = 1'b1;
                cr_wdata = cr_pick(it.rb, cr_status_q, cr_handler_q, cr_cause_q) | it.disp;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_MRD: begin
        unique case (it.opc)
          OPC_CALL, OPC_JUMP: begin
            rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = mem_rdata;
          end
          OPC_STORE: begin
            mem_we = 1'b1; mem_addr = maddr(mem_rdata); mem_wdata = c_q;
          end
          OPC_LOAD: begin
            unique case (it.md)
              MD_LD_IDX, MD_LD_POST: begin rf_we = 1'b1; rf_wdata = mem_rdata; end
              MD_CR_IDX: begin cr_we = 1'b1; cr_wdata = mem_rdata; end
              MD_CR_POST: begin
                cr_we = 1'b1; cr_wdata = mem_rdata;
                rf_we = 1'b1; rf_waddr = it.rb; rf_wdata = b_q + it.disp;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_STEP3: begin
        unique case (it.opc)
          OPC_SWI: begin
            rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = cr_handler_q + 32'd4;
            swi_upd = 1'b1;
          end
          OPC_SWAP: begin
            rf_we = 1'b1; rf_waddr = PC_IDX; rf_wdata = pc4;
          end
          OPC_STORE: begin
            mem_we = 1'b1; mem_addr = maddr(a_q + it.disp); mem_wdata = c_q;
          end
          OPC_LOAD: begin
            rf_we = 1'b1; rf_waddr = it.rb; rf_wdata = b_q + it.disp;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          rf_we = 1'b1; rf_wdata = div_quo;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.clearing = state_q == ST_CLEAR;
  assign stat_o.done     = (state_q == ST_FIN) && out_ready_i;
  assign stat_o.pc       = pc_q;
  assign stat_o.running  = running_q;
  assign stat_o.rd       = rd_q;
  assign stat_o.fault    = fault_q;

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    loc_q   <= loc_d;
    rd_q    <= rd_d;
    fault_q <= fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_row_q    <= '0;
      running_q    <= 1'b1;
      pc_q         <= '0;
      sp_q         <= '0;
      rf_valid_q   <= '0;
      cr_status_q  <= '0;
      cr_handler_q <= '0;
      cr_cause_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_row_q <= clr_row_q + 1'b1;
      if (running_clr) running_q <= 1'b0;
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
        if (rf_waddr == PC_IDX) pc_q <= rf_wdata;
        if (rf_waddr == SP_IDX) sp_q <= rf_wdata;
      end
      if (swi_upd) begin
        cr_cause_q  <= SWI_CAUSE;
        cr_status_q <= cr_status_q & STATUS_MASK;
      end else if (cr_we) begin
        unique case (cr_widx)
          CR_STATUS:  cr_status_q  <= cr_wdata;
          CR_HANDLER: cr_handler_q <= cr_wdata;
          CR_CAUSE:   cr_cause_q   <= cr_wdata;
          default: ;
        endcase
      end
    end
  end

  // register file: one write, two registered reads; unwritten entries read zero
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rf_waddr] <= rf_wdata;
    rd0_q <= rf_valid_q[rd0_idx] ? rf_q[rd0_idx] : '0;
    rd1_q <= rf_valid_q[rd1_idx] ? rf_q[rd1_idx] : '0;
  end

  // byte lanes: lane k holds bytes whose address is k modulo four
  assign w64        = {mem_wdata, mem_wdata} << {mem_addr[1:0], 3'b000};
  assign bank_wdata = (state_q == ST_CLEAR) ? 32'd0 : w64[63:32];
  assign bank_we    = mem_we || (state_q == ST_CLEAR);
  assign r64        = {bank_rdata_q, bank_rdata_q} >> {rd_lo_q, 3'b000};
  assign mem_rdata  = r64[31:0];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (state_q == ST_CLEAR) begin
        bank_row[k] = clr_row_q;
      end else begin
        bank_row[k] = mem_addr[AW-1:2] + RAW'(2'(k) < mem_addr[1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lo_q <= mem_addr[1:0];
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] mem_q [ROWS];
    always_ff @(posedge clk_i) begin
      if (bank_we) mem_q[bank_row[k]] <= bank_wdata[8*k +: 8];
      bank_rdata_q[8*k +: 8] <= mem_q[bank_row[k]];
    end
  end

endmodule

/* rtl/small_risc_execute_unit.sv */
// Top level of the execute unit: front queue, back sequencer and result register.
// For an instruction the back end reads the ra and rb registers through its two
// registered read ports, then rc, and then walks its register, control register
// and memory writes in order. Memory-indirect forms add a state for the registered
// memory read, and divide waits on the bit-serial divider. After reset the data
// memory is cleared one word row per cycle, with full held high meanwhile. Up to
// two words queue ahead of the back end, and one result waits on the output.
`include "assert_macros.svh"
module small_risc_execute_unit import sre_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
  parameter int unsigned PC_INDEX  = PC_INDEX_DEF,
  parameter int unsigned SP_INDEX  = SP_INDEX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation_i,
  input  logic [31:0]        instr_word_i,
  input  logic [15:0]        host_address_i,
  input  logic signed [31:0] host_data_i,
  input  logic [3:0]         reg_select_i,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        pc_value_o,
  output logic               is_running_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         fault_o
);

  item_t q_item;
  logic  q_valid, q_pop, out_valid_q, out_free;
  stat_t stat;
  logic [31:0] pc_q, rd_q;
  logic        run_q;
  logic [1:0]  fault_q;

  sre_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .hold_i         (stat.clearing),
    .operation_i    (operation_i),
    .instr_word_i   (instr_word_i),
    .host_address_i (host_address_i),
    .host_data_i    ($unsigned(host_data_i)),
    .reg_select_i   (reg_select_i),
    .full_o         (full),
    .pop_i          (q_pop),
    .valid_o        (q_valid),
    .item_o         (q_item)
  );

  sre_back #(
    .MEM_BYTES (MEM_BYTES),
    .PC_INDEX  (PC_INDEX),
    .SP_INDEX  (SP_INDEX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_ready_i (out_free),
    .stat_o      (stat)
  );

  // hold the finished word until it is popped
  assign out_free     = !out_valid_q || pop;
  assign empty        = !out_valid_q;
  assign pc_value_o   = pc_q;
  assign is_running_o = run_q;
  assign read_value_o = $signed(rd_q);
  assign fault_o      = fault_q;

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      pc_q    <= stat.pc;
      run_q   <= stat.running;
      rd_q    <= stat.rd;
      fault_q <= stat.fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  `SRE_ASSERT(a_done_shows, clk_i, rst_ni, stat.done |=> !empty, "finished word not shown")
  `SRE_NEVER(a_clear_quiet, clk_i, rst_ni, stat.clearing && stat.done, "result during clear")
  `SRE_ASSERT(a_pop_valid, clk_i, rst_ni, q_pop |-> q_valid, "back end took from empty queue")
  `SRE_ASSERT(a_clear_full, clk_i, rst_ni, stat.clearing |-> full, "input open during clear")

endmodule

/* sim/tb_small_risc_execute_unit.sv */
// Self-checking testbench for the execute unit: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_small_risc_execute_unit;
  import sre_pkg::*;

  typedef struct {
    logic [31:0] pc;
    logic        running;
    logic [31:0] rd;
    logic [1:0]  fault;
  } outcome_t;

  class exec_scoreboard;
    logic [31:0] gpr [16];
    logic [31:0] ctl [3];
    logic        run_flag;
    logic [7:0]  mem [65536];
    outcome_t    pending_results [$];
    int          mismatches;
    int          checked;
    int          instrs;
    int          host_ops;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (ctl[i]) ctl[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      run_flag = 1'b1;
    endfunction

    function logic [31:0] load_word(logic [31:0] addr);
      logic [31:0] v;
      logic [31:0] a;
      v = '0;
      for (int i = 0; i < 4; i++) begin
        a = addr + i;
        v[8*i +: 8] = mem[a[15:0]];
      end
      return v;
    endfunction

    function void store_word(logic [31:0] addr, logic [31:0] v);
      logic [31:0] a;
      for (int i = 0; i < 4; i++) begin
        a = addr + i;
        mem[a[15:0]] = v[8*i +: 8];
      end
    endfunction

    function logic [31:0] ctl_read(logic [3:0] idx);
      return (idx < 3) ? ctl[idx] : 32'h0;
    endfunction

    function void ctl_write(logic [3:0] idx, logic [31:0] v);
      if (idx < 3) ctl[idx] = v;
    endfunction

    function logic [1:0] run_instr(logic [31:0] w);
      logic [3:0]  op, md, ra, rb, rc;
      logic [11:0] d12;
      logic [31:0] d, a, b, c, sp, loc;
      logic        take;
      longint      qs;
      logic [1:0]  flt;
      op = w[31:28]; md = w[27:24]; ra = w[23:20]; rb = w[19:16]; rc = w[15:12];
      d12 = {w[7:0], w[11:8]};
      d = {{20{d12[11]}}, d12};
      a = gpr[ra]; b = gpr[rb]; c = gpr[rc];
      flt = FLT_NONE;
      case (op)
        OPC_HALT: begin
          run_flag = 1'b0;
          gpr[PC_INDEX_DEF] += 4;
        end
        OPC_SWI: begin
          sp = gpr[SP_INDEX_DEF];
          store_word(sp - 4, gpr[PC_INDEX_DEF] + 4);
          store_word(sp - 8, ctl[CR_STATUS]);
          gpr[SP_INDEX_DEF] = sp - 8;
          ctl[CR_CAUSE] = SWI_CAUSE;
          ctl[CR_STATUS] &= STATUS_MASK;
          gpr[PC_INDEX_DEF] = ctl[CR_HANDLER] + 4;
        end
        OPC_CALL: begin
          sp = gpr[SP_INDEX_DEF];
          store_word(sp - 4, gpr[PC_INDEX_DEF] + 4);
          gpr[SP_INDEX_DEF] = sp - 4;
          loc = gpr[ra] + gpr[rb] + d;
          if (md == MD_CALL_DIR) gpr[PC_INDEX_DEF] = loc;
          else if (md == MD_CALL_IND) gpr[PC_INDEX_DEF] = load_word(loc);
        end
        OPC_JUMP: begin
          loc = gpr[PC_INDEX_DEF] + 4;
          case (md[2:0])
            JC_ALWAYS: take = (md == MD_JMP_ALW) || (md == MD_JMP_AIND);
            JC_EQ:     take = (b == c);
            JC_NE:     take = (b != c);
            JC_GT:     take = ($signed(b) > $signed(c));
            default:   take = 1'b0;
          endcase
          if (take) begin
            loc = a + d;
            if (md[JMP_IND_BIT]) loc = load_word(loc);
          end
          gpr[PC_INDEX_DEF] = loc;
        end
        OPC_SWAP: begin
          gpr[rb] = gpr[rc];
          gpr[rc] = b;
          gpr[PC_INDEX_DEF] += 4;
        end
        OPC_ARITH: begin
          gpr[PC_INDEX_DEF] += 4;
          case (md)
            MD_ADD: gpr[ra] = b + c;
            MD_SUB: gpr[ra] = b - c;
            MD_MUL: gpr[ra] = b * c;
            MD_DIV: begin
              if (c == 0) begin
                gpr[ra] = 32'hFFFF_FFFF;
                flt = FLT_DIV0;
              end else begin
                qs = longint'($signed(b)) / longint'($signed(c));
                gpr[ra] = qs[31:0];
              end
            end
            default: ;
          endcase
        end
        OPC_LOGIC: begin
          gpr[PC_INDEX_DEF] += 4;
          case (md)
            MD_NOT: gpr[ra] = ~b;
            MD_AND: gpr[ra] = b & c;
            MD_OR:  gpr[ra] = b | c;
            MD_XOR: gpr[ra] = b ^ c;
            default: ;
          endcase
        end
        OPC_SHIFT: begin
          gpr[PC_INDEX_DEF] += 4;
          if (md == MD_SHL) gpr[ra] = (c >= 32) ? 32'h0 : (b << c);
          else if (md == MD_SAR) gpr[ra] = (c >= 32) ? {32{b[31]}} : 32'($signed(b) >>> c);
        end
        OPC_STORE: begin
          gpr[PC_INDEX_DEF] += 4;
          case (md)
            MD_ST_IDX: store_word(a + b + d, c);
            MD_ST_IND: store_word(load_word(a + b + d), c);
            MD_ST_PRE: begin
              gpr[ra] = a + d;
              store_word(a + d, c);
            end
            default: ;
          endcase
        end
        OPC_LOAD: begin
          gpr[PC_INDEX_DEF] += 4;
          case (md)
            MD_LD_CR:   gpr[ra] = ctl_read(rb);
            MD_LD_ADDI: gpr[ra] = b + d;
            MD_LD_IDX:  gpr[ra] = load_word(b + c + d);
            MD_LD_POST: begin
              gpr[ra] = load_word(b);
              gpr[rb] = b + d;
            end
            MD_CR_MOV:  ctl_write(ra, b);
            MD_CR_OR:   ctl_write(ra, ctl_read(rb) | d);
            MD_CR_IDX:  ctl_write(ra, load_word(b + c + d));
            MD_CR_POST: begin
              ctl_write(ra, load_word(b));
              gpr[rb] = b + d;
            end
            default: ;
          endcase
        end
        default: flt = FLT_BAD;
      endcase
      return flt;
    endfunction

    function void note_item(logic [2:0] opn, logic [31:0] w, logic [15:0] haddr,
                            logic [31:0] hdata, logic [3:0] rsel);
      outcome_t r;
      r.rd = '0;
      r.fault = FLT_NONE;
      if (opn == OPN_EXEC) instrs++; else host_ops++;
      case (opn)
        OPN_EXEC:   r.fault = run_flag ? run_instr(w) : FLT_HALTED;
        OPN_MEM_WR: store_word({16'h0, haddr}, hdata);
        OPN_MEM_RD: r.rd = load_word({16'h0, haddr});
        OPN_REG_WR: gpr[rsel] = hdata;
        OPN_REG_RD: r.rd = gpr[rsel];
        OPN_CR_RD:  r.rd = ctl_read(rsel);
        default:    r.fault = FLT_BAD;
      endcase
      r.pc = gpr[PC_INDEX_DEF];
      r.running = run_flag;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] pc, logic running, logic [31:0] rd,
                               logic [1:0] fault);
      outcome_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: pc %h rd %h", pc, rd);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (pc !== e.pc || running !== e.running || rd !== e.rd || fault !== e.fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: exp pc %h run %b rd %h fault %0d, got pc %h run %b rd %h fault %0d",
                   checked, e.pc, e.running, e.rd, e.fault, pc, running, rd, fault);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [2:0]         operation_i;
  logic [31:0]        instr_word_i;
  logic [15:0]        host_address_i;
  logic signed [31:0] host_data_i;
  logic [3:0]         reg_select_i;
  logic               empty;
  logic               pop;
  logic [31:0]        pc_value_o;
  logic               is_running_o;
  logic signed [31:0] read_value_o;
  logic [1:0]         fault_o;

  exec_scoreboard sb;
  int             idle_cycles;
  bit             recv_busy_off;

  small_risc_execute_unit uut (
    .clk_i, .rst_ni, .push, .full, .operation_i, .instr_word_i, .host_address_i,
    .host_data_i, .reg_select_i, .empty, .pop, .pc_value_o, .is_running_o,
    .read_value_o, .fault_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] encode(logic [3:0] op, logic [3:0] md, logic [3:0] ra,
                                         logic [3:0] rb, logic [3:0] rc, logic [11:0] d);
    return {op, md, ra, rb, rc, d[3:0], d[11:4]};
  endfunction

  task automatic send(logic [2:0] opn, logic [31:0] w, logic [15:0] haddr,
                      logic [31:0] hdata, logic [3:0] rsel);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= opn;
    instr_word_i <= w;
    host_address_i <= haddr;
    host_data_i <= hdata;
    reg_select_i <= rsel;
    do @(posedge clk_i); while (full);
    sb.note_item(opn, w, haddr, hdata, rsel);
  endtask

  task automatic exec_instr(logic [31:0] w);
    send(OPN_EXEC, w, 16'($urandom), $urandom, 4'($urandom));
  endtask

  task automatic set_reg(logic [3:0] r, logic [31:0] v);
    send(OPN_REG_WR, $urandom, 16'($urandom), v, r);
  endtask

  task automatic random_item();
    int          pick;
    logic [3:0]  op, md;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // keep opcodes mostly known; halt is held back for the end
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(1, 9));
      md = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
      exec_instr(encode(op, md, 4'($urandom), 4'($urandom), 4'($urandom), 12'($urandom)));
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: v = $urandom_range(0, 40);
        1: v = -$urandom_range(1, 40);
        default: v = $urandom;
      endcase
      set_reg(4'($urandom), v);
    end else if (pick < 83) begin
      send(OPN_MEM_WR, $urandom, 16'($urandom), $urandom, 4'($urandom));
    end else if (pick < 89) begin
      send(OPN_MEM_RD, $urandom, 16'($urandom), $urandom, 4'($urandom));
    end else if (pick < 94) begin
      send(OPN_REG_RD, $urandom, 16'($urandom), $urandom, 4'($urandom));
    end else if (pick < 98) begin
      send(OPN_CR_RD, $urandom, 16'($urandom), $urandom, 4'($urandom));
    end else begin
      send(3'($urandom_range(6, 7)), $urandom, 16'($urandom), $urandom, 4'($urandom));
    end
  endtask

  // result side: drain words with random stalls
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(pc_value_o, is_running_o, read_value_o, fault_o);
    end
  end

  // watchdog: covers the memory clearing pass after reset
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 80000) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("small_risc_execute_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OPN_EXEC;
    instr_word_i = '0;
    host_address_i = '0;
    host_data_i = '0;
    reg_select_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_reg(4'd1, 32'h7FFF_FFFF);
    set_reg(4'd2, 32'h8000_0000);
    set_reg(4'd3, 32'hFFFF_FFFF);
    set_reg(4'd5, 32'd40);
    set_reg(SP_INDEX_DEF[3:0], 32'h0000_0004);
    exec_instr(encode(OPC_ARITH, MD_ADD, 4'd6, 4'd1, 4'd3, 12'h0));
    exec_instr(encode(OPC_ARITH, MD_SUB, 4'd6, 4'd2, 4'd1, 12'h0));
    exec_instr(encode(OPC_ARITH, MD_MUL, 4'd6, 4'd1, 4'd1, 12'h0));
    exec_instr(encode(OPC_ARITH, MD_DIV, 4'd6, 4'd2, 4'd3, 12'h0));  // overflow
    exec_instr(encode(OPC_ARITH, MD_DIV, 4'd6, 4'd1, 4'd4, 12'h0));  // by zero
    exec_instr(encode(OPC_SHIFT, MD_SHL, 4'd7, 4'd1, 4'd5, 12'h0));
    exec_instr(encode(OPC_SHIFT, MD_SAR, 4'd7, 4'd2, 4'd3, 12'h0));
    exec_instr(encode(OPC_LOGIC, MD_XOR, 4'd7, 4'd1, 4'd2, 12'h0));
    exec_instr(encode(OPC_LOAD, MD_CR_MOV, CR_HANDLER, 4'd1, 4'd0, 12'h0));
    exec_instr(encode(OPC_LOAD, MD_CR_OR, CR_STATUS, 4'd9, 4'd0, 12'h7FF));
    exec_instr(encode(OPC_SWI, 4'd0, 4'd0, 4'd0, 4'd0, 12'h0));       // stack wraps
    exec_instr(encode(OPC_CALL, MD_CALL_IND, 4'd4, 4'd4, 4'd0, 12'h800));
    exec_instr(encode(OPC_JUMP, JC_GT, 4'd1, 4'd1, 4'd2, 12'hFFC));   // signed compare
    exec_instr(encode(OPC_JUMP, 4'd4, 4'd1, 4'd1, 4'd1, 12'h0));      // unknown modifier
    exec_instr(encode(OPC_STORE, MD_ST_PRE, 4'd3, 4'd0, 4'd1, 12'hFFF));
    exec_instr(encode(OPC_SWAP, 4'd0, 4'd0, 4'd1, 4'd2, 12'h0));
    exec_instr(encode(4'hC, 4'd0, 4'd0, 4'd0, 4'd0, 12'h0));          // unknown opcode
    send(OPN_MEM_WR, '0, 16'hFFFE, 32'hA5C3_0F81, '0);                // wraps to byte 0
    send(OPN_MEM_RD, '0, 16'hFFFF, '0, '0);
    send(OPN_CR_RD, '0, '0, '0, 4'd15);
    send(3'd7, '0, '0, '0, '0);

    for (int n = 0; n < 1300; n++) begin
      random_item();
      if (n == 650) begin
        // hold the sender until the block has drained
        push <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_results.size() != 0) @(posedge clk_i);
      end
    end
    exec_instr(encode(OPC_HALT, 4'd0, 4'd0, 4'd0, 4'd0, 12'h0));
    exec_instr(encode(OPC_ARITH, MD_ADD, 4'd1, 4'd1, 4'd1, 12'h0));   // halted
    send(OPN_REG_RD, '0, '0, '0, PC_INDEX_DEF[3:0]);
    push <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d instructions and %0d host accesses, %0d results checked",
             sb.instrs, sb.host_ops, sb.checked);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("small_risc_execute_unit: match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("small_risc_execute_unit: mismatch");
    end
    $finish;
  end

endmodule
